// ===== hdl/sbbw_pkg.sv =====
// Shared types, codes and helpers for the sorted breakpoint blend weight block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sbbw_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ALU_W     = 18;

	localparam logic [16:0] ALPHA_HALF = 17'd32768;
	localparam logic [16:0] ALPHA_ONE  = 17'd65536;
	localparam logic [4:0]  DIV_LAST   = 5'd16;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_CLEAR   = 3'd1,
		OP_READ    = 3'd2,
		OP_SETPOS  = 3'd3,
		OP_SETCLIP = 3'd4,
		OP_REMOVE  = 3'd5,
		OP_QUERY   = 3'd6
	} op_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_IDX = 3'd1;
	localparam logic [2:0] ST_NO_CLIP = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ_WAIT,
		S_SP_CLIP,
		S_RM_RD,
		S_RM_WR,
		S_INS_RD,
		S_INS_CMP,
		S_Q_FIRST,
		S_Q_LAST,
		S_Q_SCAN,
		S_Q_DEN,
		S_Q_NUM,
		S_Q_DIV
	} state_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [3:0]         entry_index;
		logic signed [15:0] position;
		logic [15:0]        clip_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [3:0]         index_a;
		logic [3:0]         index_b;
		logic [15:0]        clip_a;
		logic [15:0]        clip_b;
		logic [16:0]        alpha;
		logic [15:0]        dominant_clip;
		logic signed [15:0] read_position;
		logic [15:0]        read_clip;
		logic [4:0]         sample_count;
	} res_t;

	typedef struct packed {
		logic pos;
		logic clip;
	} mem_we_t;

	typedef struct packed {
		logic [ALU_W-1:0] diff;
		logic             neg;
		logic             zero;
	} alu_res_t;

	function automatic logic signed [ALU_W-1:0] sext_pos(input logic [15:0] v);
		sext_pos = {{(ALU_W - 16){v[15]}}, v};
	endfunction

	function automatic logic signed [ALU_W-1:0] zext_rem(input logic [16:0] v);
		zext_rem = {{(ALU_W - 17){1'b0}}, v};
	endfunction

endpackage

// ===== hdl/sbbw_alu.sv =====
// Shared subtract unit: one wide subtraction with sign and zero flags.
// Depends on sbbw_pkg for the operand width and the result struct.
`timescale 1ns / 1ps

module sbbw_alu (
	input  logic signed [sbbw_pkg::ALU_W-1:0] a,
	input  logic signed [sbbw_pkg::ALU_W-1:0] b,
	output sbbw_pkg::alu_res_t                r
);
	import sbbw_pkg::*;

	logic signed [ALU_W-1:0] diff;

	assign diff   = a - b;
	assign r.diff = diff;
	assign r.neg  = diff[ALU_W-1];
	assign r.zero = (diff == '0);

endmodule

// ===== hdl/sbbw_mem.sv =====
// Sample store: position and clip arrays with one write port and one
// registered read port. Depends on sbbw_pkg for the write enable struct.
`timescale 1ns / 1ps

module sbbw_mem #(
	parameter int DEPTH = sbbw_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  sbbw_pkg::mem_we_t we,
	input  logic [AW-1:0]     waddr,
	input  logic [15:0]       wpos,
	input  logic [15:0]       wclip,
	input  logic [AW-1:0]     raddr,
	output logic [15:0]       rpos,
	output logic [15:0]       rclip
);
	import sbbw_pkg::*;

	logic [15:0] pos_mem  [DEPTH];
	logic [15:0] clip_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we.pos) begin
			pos_mem[waddr] <= wpos;
		end
		if (we.clip) begin
			clip_mem[waddr] <= wclip;
		end
		rpos  <= pos_mem[raddr];
		rclip <= clip_mem[raddr];
	end

endmodule

// ===== hdl/sorted_breakpoint_blend_weight_top.sv =====
// Add shifts each entry above the new position up by one and then writes the new sample;
// remove shifts the entries above it down by one; set position is a remove then an insert;
// query scans for the bracketing pair and then runs the 17-step divide.
// One command at a time: busy is high from the accepting edge until the result strobe.
// The result shows for one cycle on done/result; the receiver cannot stall it.
// Reset (arst_n low, asynchronous) empties the table; the sample store itself is not cleared.
`timescale 1ns / 1ps

module sorted_breakpoint_blend_weight_top #(
	parameter int DEPTH = sbbw_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sbbw_pkg::cmd_t cmd,
	output logic           done,
	output sbbw_pkg::res_t result
);
	import sbbw_pkg::*;

	// Address width, count width, and a width that holds both a count and an
	// entry index for range checks.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > 4) ? CW : 4;

	state_t state_q, state_d;

	// Latched command.
	logic [2:0]         op_q;
	logic [3:0]         idx_q;
	logic signed [15:0] p_q;
	logic [15:0]        clip_q;

	// Table bookkeeping and the walking pointer used by every shift and scan.
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] j_q;
	logic [CW-1:0] jm1, jp1;

	// Query segment and divider registers.
	logic [15:0] lo_q, clo_q, hi_q, chi_q, den_q;
	logic [16:0] rem_q, quo_q, trial;
	logic [4:0]  step_q;

	logic done_q;
	res_t res_q, res_d;
	logic fin;

	// Store and shared unit connections.
	mem_we_t       we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wpos, wclip, rpos, rclip;
	logic signed [ALU_W-1:0] alu_a, alu_b;
	alu_res_t      alu_r;

	logic accept;
	logic bad_idx, full, tie_up, move, p_le, qbit, last_step;
	logic [16:0] alpha_d;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	assign jm1 = j_q - CW'(1);
	assign jp1 = j_q + CW'(1);

	assign bad_idx = (IW'(idx_q) >= IW'(cnt_q));
	assign full    = (cnt_q == CW'(DEPTH));

	// A moved sample keeps its place among equal positions by its former index,
	// so during a set-position insert equals at or above that index move up.
	assign tie_up = (op_q == OP_SETPOS) && (IW'(jm1) >= IW'(idx_q));
	assign move   = alu_r.neg || (alu_r.zero && tie_up);

	// The compare states all form parameter minus stored position.
	assign p_le = alu_r.neg || alu_r.zero;

	// Restoring division: the first step compares the difference itself (the
	// quotient can reach one), later steps shift the remainder left first.
	assign trial     = (step_q == '0) ? rem_q : {rem_q[15:0], 1'b0};
	assign qbit      = !alu_r.neg;
	assign last_step = (step_q == DIV_LAST);
	assign alpha_d   = {quo_q[15:0], qbit};

	sbbw_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wpos (wpos),
		.wclip(wclip),
		.raddr(raddr),
		.rpos (rpos),
		.rclip(rclip)
	);

	sbbw_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.r(alu_r)
	);

	// Operand selection for the one shared subtractor.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			S_INS_CMP, S_Q_FIRST, S_Q_LAST, S_Q_SCAN: begin
				alu_a = sext_pos(p_q);
				alu_b = sext_pos(rpos);
			end
			S_Q_DEN: begin
				alu_a = sext_pos(hi_q);
				alu_b = sext_pos(lo_q);
			end
			S_Q_NUM: begin
				alu_a = sext_pos(p_q);
				alu_b = sext_pos(lo_q);
			end
			S_Q_DIV: begin
				alu_a = zext_rem(trial);
				alu_b = zext_rem({1'b0, den_q});
			end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				unique case (op_q)
					OP_ADD: begin
						if (clip_q != '0 && !full) begin
							state_d = S_INS_RD;
						end
					end
					OP_READ: begin
						if (!bad_idx) begin
							state_d = S_READ_WAIT;
						end
					end
					OP_SETPOS: begin
						if (!bad_idx) begin
							state_d = S_SP_CLIP;
						end
					end
					OP_REMOVE: begin
						if (!bad_idx) begin
							state_d = S_RM_RD;
						end
					end
					OP_QUERY: begin
						if (cnt_q != '0) begin
							state_d = S_Q_FIRST;
						end
					end
					default: ;
				endcase
			end
			S_READ_WAIT: state_d = S_IDLE;
			S_SP_CLIP:   state_d = S_RM_RD;
			S_RM_RD: begin
				if (jp1 == cnt_q) begin
					state_d = (op_q == OP_SETPOS) ? S_INS_RD : S_IDLE;
				end else begin
					state_d = S_RM_WR;
				end
			end
			S_RM_WR:  state_d = S_RM_RD;
			S_INS_RD: state_d = (j_q == '0) ? S_IDLE : S_INS_CMP;
			S_INS_CMP: state_d = move ? S_INS_RD : S_IDLE;
			S_Q_FIRST: state_d = p_le ? S_IDLE : S_Q_LAST;
			S_Q_LAST:  state_d = alu_r.neg ? S_Q_SCAN : S_IDLE;
			S_Q_SCAN:  state_d = p_le ? S_Q_DEN : S_Q_SCAN;
			S_Q_DEN:   state_d = S_Q_NUM;
			S_Q_NUM:   state_d = S_Q_DIV;
			S_Q_DIV:   state_d = last_step ? S_IDLE : S_Q_DIV;
			default:   state_d = S_IDLE;
		endcase
	end

	// Store control, count update and the result word.
	always_comb begin
		we    = '0;
		waddr = AW'(j_q);
		wpos  = rpos;
		wclip = rclip;
		raddr = '0;
		cnt_d = cnt_q;
		fin   = 1'b0;
		res_d = '0;
		unique case (state_q)
			S_DECODE: begin
				unique case (op_q)
					OP_ADD: begin
						if (clip_q == '0) begin
							fin          = 1'b1;
							res_d.status = ST_NO_CLIP;
						end else if (full) begin
							fin          = 1'b1;
							res_d.status = ST_FULL;
						end
					end
					OP_CLEAR: begin
						cnt_d = '0;
						fin   = 1'b1;
					end
					OP_READ, OP_SETPOS, OP_REMOVE: begin
						raddr = AW'(idx_q);
						if (bad_idx) begin
							fin          = 1'b1;
							res_d.status = ST_BAD_IDX;
						end
					end
					OP_SETCLIP: begin
						fin = 1'b1;
						if (bad_idx) begin
							res_d.status = ST_BAD_IDX;
						end else if (clip_q == '0) begin
							res_d.status = ST_NO_CLIP;
						end else begin
							we.clip = 1'b1;
							waddr   = AW'(idx_q);
							wclip   = clip_q;
						end
					end
					OP_QUERY: begin
						if (cnt_q == '0) begin
							fin          = 1'b1;
							res_d.status = ST_EMPTY;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			S_READ_WAIT: begin
				fin                 = 1'b1;
				res_d.read_position = rpos;
				res_d.read_clip     = rclip;
			end
			S_RM_RD: begin
				raddr = AW'(jp1);
				if (jp1 == cnt_q) begin
					cnt_d = cnt_q - CW'(1);
					fin   = (op_q == OP_REMOVE);
				end
			end
			S_RM_WR: begin
				we = '{pos: 1'b1, clip: 1'b1};
			end
			S_INS_RD: begin
				raddr = AW'(jm1);
				if (j_q == '0) begin
					we    = '{pos: 1'b1, clip: 1'b1};
					wpos  = p_q;
					wclip = clip_q;
					cnt_d = cnt_q + CW'(1);
					fin   = 1'b1;
				end
			end
			S_INS_CMP: begin
				we = '{pos: 1'b1, clip: 1'b1};
				if (!move) begin
					wpos  = p_q;
					wclip = clip_q;
					cnt_d = cnt_q + CW'(1);
					fin   = 1'b1;
				end
			end
			S_Q_FIRST: begin
				raddr = AW'(cnt_q - CW'(1));
				if (p_le) begin
					fin                 = 1'b1;
					res_d.clip_a        = rclip;
					res_d.clip_b        = rclip;
					res_d.dominant_clip = rclip;
				end
			end
			S_Q_LAST: begin
				raddr = AW'(1);
				if (!alu_r.neg) begin
					fin                 = 1'b1;
					res_d.index_a       = 4'(cnt_q - CW'(1));
					res_d.index_b       = 4'(cnt_q - CW'(1));
					res_d.clip_a        = rclip;
					res_d.clip_b        = rclip;
					res_d.dominant_clip = rclip;
				end
			end
			S_Q_SCAN: begin
				raddr = AW'(jp1);
			end
			S_Q_DIV: begin
				if (last_step) begin
					fin                 = 1'b1;
					res_d.index_a       = 4'(jm1);
					res_d.index_b       = 4'(j_q);
					res_d.clip_a        = clo_q;
					res_d.clip_b        = chi_q;
					res_d.alpha         = alpha_d;
					res_d.dominant_clip = (alpha_d <= ALPHA_HALF) ? clo_q : chi_q;
				end
			end
			default: ;
		endcase
		res_d.sample_count = 5'(cnt_d);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res_d;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= cmd.op;
					idx_q  <= cmd.entry_index;
					p_q    <= cmd.position;
					clip_q <= cmd.clip_id;
				end
			end
			S_DECODE: begin
				j_q <= (op_q == OP_ADD) ? cnt_q : CW'(idx_q);
			end
			S_SP_CLIP: begin
				clip_q <= rclip;
			end
			S_RM_RD: begin
				if (jp1 == cnt_q) begin
					j_q <= cnt_q - CW'(1);
				end
			end
			S_RM_WR: begin
				j_q <= jp1;
			end
			S_INS_CMP: begin
				if (move) begin
					j_q <= jm1;
				end
			end
			S_Q_FIRST: begin
				lo_q  <= rpos;
				clo_q <= rclip;
			end
			S_Q_LAST: begin
				j_q <= CW'(1);
			end
			S_Q_SCAN: begin
				if (p_le) begin
					hi_q  <= rpos;
					chi_q <= rclip;
				end else begin
					lo_q  <= rpos;
					clo_q <= rclip;
					j_q   <= jp1;
				end
			end
			S_Q_DEN: begin
				den_q <= alu_r.diff[15:0];
			end
			S_Q_NUM: begin
				rem_q  <= alu_r.diff[16:0];
				quo_q  <= '0;
				step_q <= '0;
			end
			S_Q_DIV: begin
				rem_q  <= qbit ? alu_r.diff[16:0] : trial;
				quo_q  <= alpha_d;
				step_q <= step_q + 5'd1;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command transfer did not raise busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		IW'(cnt_q) <= IW'(DEPTH))
		else $error("sample count above table depth");

	a_alpha_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.alpha <= ALPHA_ONE))
		else $error("blend weight above one");

	a_bracket_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.index_a != result.index_b))
			|-> (result.index_b == result.index_a + 4'd1))
		else $error("bracketing indices not adjacent");
`endif

endmodule

// ===== tb/tb_sorted_breakpoint_blend_weight_top.sv =====
// Self-checking testbench for the sorted breakpoint blend weight block: it drives commands,
// predicts each result from its own copy of the sorted table and checks every field.
// Depends on sbbw_pkg and sorted_breakpoint_blend_weight_top.
`timescale 1ns / 1ps

import sbbw_pkg::*;

// Tracks the sample table as the block should hold it and keeps the results that the
// accepted commands still owe, oldest first.
class breakpoint_scoreboard;
	int          pos_tab[16];
	logic [15:0] clip_tab[16];
	int          held;
	res_t        awaited_results[$];
	int          errors;

	function new();
		held = 0;
		errors = 0;
	endfunction

	function void insert_sample(int k, int p, logic [15:0] c);
		for (int j = held; j > k; j--) begin
			pos_tab[j] = pos_tab[j - 1];
			clip_tab[j] = clip_tab[j - 1];
		end
		pos_tab[k] = p;
		clip_tab[k] = c;
		held++;
	endfunction

	function void drop_sample(int k);
		for (int j = k; j + 1 < held; j++) begin
			pos_tab[j] = pos_tab[j + 1];
			clip_tab[j] = clip_tab[j + 1];
		end
		held--;
	endfunction

	// Applies one command to the table and returns the result it must produce.
	function res_t table_outcome(cmd_t c);
		res_t        r;
		int          p;
		int          idx;
		int          k;
		int          a;
		int          b;
		int          last;
		int          i;
		longint      w;
		logic [15:0] moved_clip;
		r = '0;
		p = int'($signed(c.position));
		idx = int'(c.entry_index);
		case (c.op)
			OP_ADD: begin
				if (c.clip_id == 16'd0) begin
					r.status = ST_NO_CLIP;
				end else if (held >= 16) begin
					r.status = ST_FULL;
				end else begin
					// A new sample lands after every sample at or below its position.
					k = 0;
					while (k < held && pos_tab[k] <= p)
						k++;
					insert_sample(k, p, c.clip_id);
				end
			end
			OP_CLEAR: held = 0;
			OP_READ: begin
				if (idx >= held) begin
					r.status = ST_BAD_IDX;
				end else begin
					r.read_position = pos_tab[idx][15:0];
					r.read_clip = clip_tab[idx];
				end
			end
			OP_SETPOS: begin
				if (idx >= held) begin
					r.status = ST_BAD_IDX;
				end else begin
					// The moved sample keeps its former rank among equal positions.
					moved_clip = clip_tab[idx];
					drop_sample(idx);
					k = 0;
					for (i = 0; i < held; i++)
						if (pos_tab[i] < p || (pos_tab[i] == p && i < idx))
							k++;
					insert_sample(k, p, moved_clip);
				end
			end
			OP_SETCLIP: begin
				if (idx >= held)
					r.status = ST_BAD_IDX;
				else if (c.clip_id == 16'd0)
					r.status = ST_NO_CLIP;
				else
					clip_tab[idx] = c.clip_id;
			end
			OP_REMOVE: begin
				if (idx >= held)
					r.status = ST_BAD_IDX;
				else
					drop_sample(idx);
			end
			OP_QUERY: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					last = held - 1;
					a = 0;
					b = 0;
					w = 0;
					if (p <= pos_tab[0]) begin
						a = 0;
						b = 0;
					end else if (p >= pos_tab[last]) begin
						a = last;
						b = last;
					end else begin
						for (i = 0; i < last; i++)
							if (p >= pos_tab[i] && p <= pos_tab[i + 1])
								break;
						if (i >= last)
							i = 0;
						a = i;
						b = i + 1;
						if (pos_tab[b] > pos_tab[a] && p >= pos_tab[a])
							w = (longint'(p - pos_tab[a]) << 16) /
								longint'(pos_tab[b] - pos_tab[a]);
					end
					r.index_a = 4'(a);
					r.index_b = 4'(b);
					r.clip_a = clip_tab[a];
					r.clip_b = clip_tab[b];
					r.alpha = 17'(w);
					r.dominant_clip = (w <= longint'(ALPHA_HALF)) ? r.clip_a : r.clip_b;
				end
			end
			default: ;
		endcase
		r.sample_count = 5'(held);
		return r;
	endfunction

	function void note_command(cmd_t c);
		awaited_results.push_back(table_outcome(c));
	endfunction

	function void compare_field(string name, logic [16:0] want, logic [16:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (awaited_results.size() == 0) begin
			$error("result strobe with no command outstanding");
			errors++;
			return;
		end
		want = awaited_results.pop_front();
		compare_field("status", want.status, got.status);
		compare_field("index_a", want.index_a, got.index_a);
		compare_field("index_b", want.index_b, got.index_b);
		compare_field("clip_a", want.clip_a, got.clip_a);
		compare_field("clip_b", want.clip_b, got.clip_b);
		compare_field("alpha", want.alpha, got.alpha);
		compare_field("dominant_clip", want.dominant_clip, got.dominant_clip);
		compare_field("read_position", want.read_position, got.read_position);
		compare_field("read_clip", want.read_clip, got.read_clip);
		compare_field("sample_count", want.sample_count, got.sample_count);
	endfunction
endclass

module tb_sorted_breakpoint_blend_weight_top;

	// Opcode 7 has no meaning; the block must treat it as a no-op that still answers.
	localparam logic [2:0] OP_UNDEFINED = 3'd7;

	// Random stimulus is cut into segments, each with its own mix of commands.
	localparam int MODE_FILL  = 0;
	localparam int MODE_BUILD = 1;
	localparam int MODE_MIXED = 2;
	localparam int MODE_DRAIN = 3;

	localparam int RANDOM_ITEMS   = 1620;
	localparam int DRAIN_CYCLES   = 150;
	localparam int WATCHDOG_LIMIT = 5000;

	// Cumulative percentages for the command mix of each mode, in the order of cmd_order.
	localparam int MIX_CUTS [4][8] = '{
		'{85, 85, 88, 90, 92, 92, 100, 100},
		'{40, 41, 49, 59, 67, 75, 99, 100},
		'{20, 21, 31, 46, 56, 73, 99, 100},
		'{5, 5, 15, 25, 30, 75, 100, 100}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	res_t result;

	logic [2:0] cmd_order [8];
	breakpoint_scoreboard sb;
	int idle_cycles = 0;

	sorted_breakpoint_blend_weight_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// Results cannot be held off, so every strobe is checked at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	// The watchdog restarts whenever a transfer happens in either direction. A hang of the
	// block, or a command that never gets an answer, lets it run out.
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Mostly back-to-back or short pauses, now and then a long one. Since a pause is counted
	// from the accepting edge, it ends at every possible point of the block's work.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 5);
		else if (r < 97)
			return $urandom_range(6, 60);
		return $urandom_range(61, 200);
	endfunction

	// Positions lean toward the extremes, a coarse grid that makes ties likely, and values
	// next to samples already held, so that clamping and bracket edges are hit often.
	function automatic logic [15:0] pick_position(bit for_query);
		int r;
		int i;
		int v;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				default: v = -1;
			endcase
		end else if (r < 3) begin
			v = (int'($urandom_range(0, 7)) - 4) * 256;
		end else if (r < 6 && sb.held > 0) begin
			i = $urandom_range(0, sb.held - 1);
			if (for_query && r == 5 && i + 1 < sb.held)
				v = (sb.pos_tab[i] + sb.pos_tab[i + 1]) / 2;
			else
				v = sb.pos_tab[i] + int'($urandom_range(0, 2)) - 1;
		end else begin
			v = $urandom_range(0, 65535);
		end
		return v[15:0];
	endfunction

	function automatic cmd_t random_command(int mode);
		cmd_t c;
		int   r;
		int   k;
		c = '0;
		r = $urandom_range(0, 99);
		k = 0;
		while (k < 7 && r >= MIX_CUTS[mode][k])
			k++;
		c.op = cmd_order[k];
		// Most indices address a held sample; the rest test the range check.
		if (sb.held > 0 && $urandom_range(0, 9) < 8)
			c.entry_index = 4'($urandom_range(0, sb.held - 1));
		else
			c.entry_index = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 19))
			0: c.clip_id = 16'd0;
			1: c.clip_id = 16'hFFFF;
			default: c.clip_id = 16'($urandom_range(1, 65535));
		endcase
		c.position = pick_position(c.op == OP_QUERY);
		return c;
	endfunction

	// Presents one command after the given pause and returns at the edge that accepts it.
	// A zero pause keeps start high, so it is never lowered and raised in one time step.
	task automatic transfer_command(cmd_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_command(c);
	endtask

	task automatic send_fields(logic [2:0] op, logic [3:0] idx, logic [15:0] pos,
			logic [15:0] clip);
		cmd_t c;
		c.op = op;
		c.entry_index = idx;
		c.position = pos;
		c.clip_id = clip;
		transfer_command(c, $urandom_range(0, 3));
	endtask

	initial begin
		int   sent;
		int   mode;
		int   seg_len;
		bit   no_idle;
		cmd_t c;

		sb = new();
		cmd_order = '{OP_ADD, OP_CLEAR, OP_READ, OP_SETPOS, OP_SETCLIP, OP_REMOVE,
			OP_QUERY, OP_UNDEFINED};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A query and each indexed command on an empty table: the query reports empty, indexed ones a bad index.
		send_fields(OP_QUERY, 4'd0, 16'h0000, 16'h0000);
		send_fields(OP_READ, 4'd0, 16'h0000, 16'h0000);
		send_fields(OP_SETPOS, 4'd0, 16'h0100, 16'h0000);
		send_fields(OP_SETCLIP, 4'd0, 16'h0000, 16'h0005);
		send_fields(OP_REMOVE, 4'd0, 16'h0000, 16'h0000);
		// An add without a clip is refused.
		send_fields(OP_ADD, 4'd0, 16'h0000, 16'h0000);
		// Extreme positions, then two equal positions in the middle to check the tie order.
		send_fields(OP_ADD, 4'd0, 16'h8000, 16'hFFFF);
		send_fields(OP_ADD, 4'd0, 16'h7FFF, 16'h0001);
		send_fields(OP_ADD, 4'd0, 16'h0000, 16'h8000);
		send_fields(OP_ADD, 4'd15, 16'h0000, 16'h1234);
		// Clamp at both ends, a weight of exactly one, exactly one half, and just above half.
		send_fields(OP_QUERY, 4'd0, 16'h8000, 16'h0000);
		send_fields(OP_QUERY, 4'd0, 16'h7FFF, 16'h0000);
		send_fields(OP_QUERY, 4'd0, 16'h0000, 16'h0000);
		send_fields(OP_QUERY, 4'd0, 16'hC000, 16'h0000);
		send_fields(OP_QUERY, 4'd0, 16'hC001, 16'hFFFF);
		send_fields(OP_READ, 4'd3, 16'h0000, 16'h0000);
		send_fields(OP_READ, 4'd15, 16'h0000, 16'h0000);
		// For set clip the index is checked before the clip.
		send_fields(OP_SETCLIP, 4'd15, 16'h0000, 16'h0000);
		send_fields(OP_SETCLIP, 4'd1, 16'h0000, 16'h0000);
		send_fields(OP_SETCLIP, 4'd1, 16'h0000, 16'hABCD);
		// Moves onto equal positions: one keeps its place, one goes ahead of its equal.
		send_fields(OP_SETPOS, 4'd2, 16'h0000, 16'h0000);
		send_fields(OP_SETPOS, 4'd0, 16'h7FFF, 16'h0000);
		send_fields(OP_REMOVE, 4'd3, 16'h0000, 16'h0000);
		send_fields(OP_UNDEFINED, 4'd15, 16'hFFFF, 16'hFFFF);
		send_fields(OP_CLEAR, 4'd0, 16'h0000, 16'h0000);
		send_fields(OP_QUERY, 4'd0, 16'h1234, 16'h0000);

		// Random segments. The first one fills the table so that a full table is refused
		// early; later fill segments repeat that with other contents.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = (sent == 0) ? MODE_FILL : $urandom_range(MODE_FILL, MODE_DRAIN);
			seg_len = (mode == MODE_FILL) ? $urandom_range(25, 40) : $urandom_range(10, 60);
			no_idle = ($urandom_range(0, 4) == 0);
			for (int j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
				c = random_command(mode);
				transfer_command(c, no_idle ? 0 : pick_gap());
				sent++;
			end
		end
		start <= 1'b0;

		// Wait for the last answers, then a little longer to catch any stray strobe.
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/sbbw_pkg.sv
hdl/sbbw_alu.sv
hdl/sbbw_mem.sv
hdl/sorted_breakpoint_blend_weight_top.sv
tb/tb_sorted_breakpoint_blend_weight_top.sv
